>>> src/prd_pkg.sv
package prd_pkg;

  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned PAL_IDX_W     = $clog2(PALETTE_DEPTH);
  localparam int unsigned FRAME_PIXELS  = 102400;
  localparam int unsigned ADDR_W        = 17;
  localparam int unsigned COLOR_W       = 16;
  localparam int unsigned COUNT_W       = 8;
  localparam int unsigned SHIFT_W       = 5;
  localparam int unsigned CFG_IDX_W     = 3;

  localparam logic [ADDR_W-1:0] FRAME_END = ADDR_W'(FRAME_PIXELS);

  // Opcode boundaries
  localparam logic [7:0] OP_SKIP        = 8'h00;
  localparam logic [7:0] OP_REPEAT_MIN  = 8'h81;
  localparam logic [7:0] OP_REPEAT_BASE = 8'h80;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RED_RS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_LS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_RS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_LS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_RS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_LS  = 3'd5;

  localparam logic [SHIFT_W-1:0] RED_RS_RST   = 5'd3;
  localparam logic [SHIFT_W-1:0] RED_LS_RST   = 5'd11;
  localparam logic [SHIFT_W-1:0] GREEN_RS_RST = 5'd2;
  localparam logic [SHIFT_W-1:0] GREEN_LS_RST = 5'd5;
  localparam logic [SHIFT_W-1:0] BLUE_RS_RST  = 5'd3;
  localparam logic [SHIFT_W-1:0] BLUE_LS_RST  = 5'd0;

  typedef enum logic [7:0] {
    PH_COUNT_LO = 8'b0000_0001,
    PH_COUNT_HI = 8'b0000_0010,
    PH_PALETTE  = 8'b0000_0100,
    PH_OPCODE   = 8'b0000_1000,
    PH_SKIP_LO  = 8'b0001_0000,
    PH_SKIP_HI  = 8'b0010_0000,
    PH_LITERAL  = 8'b0100_0000,
    PH_REPEAT   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] red_rs;
    logic [SHIFT_W-1:0] red_ls;
    logic [SHIFT_W-1:0] green_rs;
    logic [SHIFT_W-1:0] green_ls;
    logic [SHIFT_W-1:0] blue_rs;
    logic [SHIFT_W-1:0] blue_ls;
  } prd_cfg_t;

  // One parsed byte: an optional palette write and an optional run result
  typedef struct packed {
    logic                 wr_en;
    logic [PAL_IDX_W-1:0] wr_idx;
    logic [COLOR_W-1:0]   wr_color;
    logic                 emit;
    logic                 marker;
    logic [PAL_IDX_W-1:0] rd_idx;
    logic [ADDR_W-1:0]    addr;
    logic [COUNT_W-1:0]   count;
    logic                 done;
  } prd_cmd_t;

  function automatic logic [COLOR_W-1:0] pack_term(input logic [7:0] b,
                                                   input logic [SHIFT_W-1:0] rs,
                                                   input logic [SHIFT_W-1:0] ls);
    logic [COLOR_W-1:0] t;
    t = COLOR_W'(b) >> rs;
    return t << ls;
  endfunction

endpackage

>>> src/prd_if.sv
interface prd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       frame_restart;

  modport source (output valid, output stream_byte, output frame_restart, input ready);
  modport sink   (input valid, input stream_byte, input frame_restart, output ready);
endinterface

interface prd_out_if;
  logic                          valid;
  logic                          ready;
  logic [prd_pkg::ADDR_W-1:0]    pixel_address;
  logic [prd_pkg::COLOR_W-1:0]   pixel_color;
  logic [prd_pkg::COUNT_W-1:0]   run_count;
  logic                          frame_done;

  modport source (output valid, output pixel_address, output pixel_color,
                  output run_count, output frame_done, input ready);
  modport sink   (input valid, input pixel_address, input pixel_color,
                  input run_count, input frame_done, output ready);
endinterface

interface prd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [prd_pkg::CFG_IDX_W-1:0] index;
  logic [prd_pkg::SHIFT_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/prd_palette.sv
module prd_palette (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [prd_pkg::PAL_IDX_W-1:0]   wr_idx,
  input  logic [prd_pkg::COLOR_W-1:0]     wr_data,
  input  logic                            rd_en,
  input  logic [prd_pkg::PAL_IDX_W-1:0]   rd_idx,
  output logic [prd_pkg::COLOR_W-1:0]     rd_data
);

  logic [prd_pkg::COLOR_W-1:0]       mem [prd_pkg::PALETTE_DEPTH];
  logic [prd_pkg::PALETTE_DEPTH-1:0] valid_r;
  logic [prd_pkg::COLOR_W-1:0]       rd_data_r;
  logic                              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
      rd_vld_r  <= valid_r[rd_idx];
    end
  end

  // Unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

>>> src/prd_parser.sv
module prd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           stream_byte,
  input  logic                 frame_restart,
  input  prd_pkg::prd_cfg_t    cfg,
  output prd_pkg::prd_cmd_t    cmd
);

  prd_pkg::phase_t                  phase_r, phase_nxt, phase_cur;
  logic [15:0]                      entries_left_r, entries_left_nxt;
  logic [prd_pkg::PAL_IDX_W-1:0]    entry_idx_r, entry_idx_nxt;
  logic                             entry_ovf_r, entry_ovf_nxt;
  logic [15:0]                      color_bytes_r, color_bytes_nxt;
  logic [prd_pkg::ADDR_W-1:0]       write_offset_r, write_offset_nxt;
  logic [7:0]                       literal_left_r, literal_left_nxt;
  logic [7:0]                       skip_lo_r, skip_lo_nxt;

  logic [15:0]                      count_full;
  logic [prd_pkg::ADDR_W:0]         skip_sum;
  logic [prd_pkg::ADDR_W-1:0]       offset_inc;
  logic [prd_pkg::ADDR_W-1:0]       rest;
  logic [7:0]                       lit_dec;
  logic                             clip;
  logic [prd_pkg::COLOR_W-1:0]      packed_color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= prd_pkg::PH_COUNT_LO;
      entries_left_r <= '0;
      entry_idx_r    <= '0;
      entry_ovf_r    <= 1'b0;
      color_bytes_r  <= '0;
      write_offset_r <= '0;
      literal_left_r <= '0;
      skip_lo_r      <= '0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      entries_left_r <= entries_left_nxt;
      entry_idx_r    <= entry_idx_nxt;
      entry_ovf_r    <= entry_ovf_nxt;
      color_bytes_r  <= color_bytes_nxt;
      write_offset_r <= write_offset_nxt;
      literal_left_r <= literal_left_nxt;
      skip_lo_r      <= skip_lo_nxt;
    end
  end

  assign count_full   = {stream_byte, entries_left_r[7:0]};
  assign skip_sum     = {1'b0, write_offset_r} + {2'b00, stream_byte, skip_lo_r};
  assign offset_inc   = write_offset_r + prd_pkg::ADDR_W'(1);
  assign rest         = prd_pkg::FRAME_END - write_offset_r;
  assign lit_dec      = literal_left_r - 8'd1;
  assign clip         = {{(prd_pkg::ADDR_W-8){1'b0}}, literal_left_r} >= rest;
  assign packed_color = prd_pkg::pack_term(color_bytes_r[7:0], cfg.red_rs, cfg.red_ls)
                      + prd_pkg::pack_term(color_bytes_r[15:8], cfg.green_rs, cfg.green_ls)
                      + prd_pkg::pack_term(stream_byte, cfg.blue_rs, cfg.blue_ls);

  always_comb begin
    phase_nxt        = phase_r;
    entries_left_nxt = entries_left_r;
    entry_idx_nxt    = entry_idx_r;
    entry_ovf_nxt    = entry_ovf_r;
    color_bytes_nxt  = color_bytes_r;
    write_offset_nxt = write_offset_r;
    literal_left_nxt = literal_left_r;
    skip_lo_nxt      = skip_lo_r;
    cmd              = '0;
    cmd.wr_idx       = entry_idx_r;
    cmd.wr_color     = packed_color;
    cmd.rd_idx       = stream_byte;
    cmd.addr         = write_offset_r;

    phase_cur = frame_restart ? prd_pkg::PH_COUNT_LO : phase_r;

    unique case (phase_cur)
      prd_pkg::PH_COUNT_LO: begin
        entries_left_nxt = {8'h00, stream_byte};
        phase_nxt        = prd_pkg::PH_COUNT_HI;
      end
      prd_pkg::PH_COUNT_HI: begin
        entries_left_nxt = count_full;
        entry_idx_nxt    = '0;
        entry_ovf_nxt    = 1'b0;
        literal_left_nxt = '0;
        write_offset_nxt = '0;
        phase_nxt        = (count_full != 16'h0000) ? prd_pkg::PH_PALETTE
                                                    : prd_pkg::PH_OPCODE;
      end
      prd_pkg::PH_PALETTE: begin
        // literal_left tracks the byte position within the triplet here
        if (literal_left_r == 8'd0) begin
          color_bytes_nxt  = {8'h00, stream_byte};
          literal_left_nxt = 8'd1;
        end else if (literal_left_r == 8'd1) begin
          color_bytes_nxt  = {stream_byte, color_bytes_r[7:0]};
          literal_left_nxt = 8'd2;
        end else begin
          cmd.wr_en        = !entry_ovf_r;
          entry_idx_nxt    = entry_idx_r + prd_pkg::PAL_IDX_W'(1);
          if (&entry_idx_r) begin
            entry_ovf_nxt = 1'b1;
          end
          entries_left_nxt = entries_left_r - 16'd1;
          literal_left_nxt = '0;
          if (entries_left_r == 16'd1) begin
            phase_nxt = prd_pkg::PH_OPCODE;
          end
        end
      end
      prd_pkg::PH_OPCODE: begin
        if (stream_byte == prd_pkg::OP_SKIP) begin
          phase_nxt = prd_pkg::PH_SKIP_LO;
        end else if (stream_byte < prd_pkg::OP_REPEAT_MIN) begin
          literal_left_nxt = stream_byte;
          phase_nxt        = prd_pkg::PH_LITERAL;
        end else begin
          literal_left_nxt = stream_byte - prd_pkg::OP_REPEAT_BASE;
          phase_nxt        = prd_pkg::PH_REPEAT;
        end
      end
      prd_pkg::PH_SKIP_LO: begin
        skip_lo_nxt = stream_byte;
        phase_nxt   = prd_pkg::PH_SKIP_HI;
      end
      prd_pkg::PH_SKIP_HI: begin
        if (skip_sum >= {1'b0, prd_pkg::FRAME_END}) begin
          write_offset_nxt = prd_pkg::FRAME_END;
          cmd.emit         = 1'b1;
          cmd.marker       = 1'b1;
          cmd.addr         = prd_pkg::FRAME_END;
          cmd.done         = 1'b1;
          phase_nxt        = prd_pkg::PH_COUNT_LO;
        end else begin
          write_offset_nxt = skip_sum[prd_pkg::ADDR_W-1:0];
          phase_nxt        = prd_pkg::PH_OPCODE;
        end
      end
      prd_pkg::PH_LITERAL: begin
        literal_left_nxt = lit_dec;
        if (write_offset_r < prd_pkg::FRAME_END) begin
          write_offset_nxt = offset_inc;
          cmd.emit         = 1'b1;
          cmd.count        = prd_pkg::COUNT_W'(1);
          cmd.done         = (lit_dec == 8'd0) && (offset_inc >= prd_pkg::FRAME_END);
          if (lit_dec == 8'd0) begin
            phase_nxt = cmd.done ? prd_pkg::PH_COUNT_LO : prd_pkg::PH_OPCODE;
          end
        end else if (lit_dec == 8'd0) begin
          // Last literal byte past the frame end closes the frame
          cmd.emit   = 1'b1;
          cmd.marker = 1'b1;
          cmd.addr   = prd_pkg::FRAME_END;
          cmd.done   = 1'b1;
          phase_nxt  = prd_pkg::PH_COUNT_LO;
        end
      end
      prd_pkg::PH_REPEAT: begin
        cmd.emit         = 1'b1;
        cmd.count        = clip ? rest[prd_pkg::COUNT_W-1:0] : literal_left_r;
        cmd.done         = clip;
        write_offset_nxt = clip ? prd_pkg::FRAME_END
                                : write_offset_r + {{(prd_pkg::ADDR_W-8){1'b0}}, literal_left_r};
        literal_left_nxt = '0;
        phase_nxt        = clip ? prd_pkg::PH_COUNT_LO : prd_pkg::PH_OPCODE;
      end
      default: begin
        phase_nxt = prd_pkg::PH_COUNT_LO;
      end
    endcase
  end

endmodule

>>> src/palette_rle_frame_decoder.sv
// Channel  Role    Payload                                              Transfer
// -------  ------  ---------------------------------------------------  ------------------
// in_bus   sink    stream_byte[7:0], frame_restart                      valid && ready
// out_bus  source  pixel_address[16:0], pixel_color[15:0],              valid && ready
//                  run_count[7:0], frame_done
// cfg_bus  sink    index[2:0], data[4:0]                                valid && ready
//
// One stream byte is taken every cycle while in_bus.ready is high. A run
// result leaves through the synchronous palette read in the read stage and
// then the output register. rst_n is synchronous; palette valid bits clear
// in the same cycle, so no clearing pass runs. The result path holds one
// result in the read stage and one in the output register; a byte is refused
// only while both are full and out_bus stalls. cfg_bus is always ready.
module palette_rle_frame_decoder (
  input logic       clk,
  input logic       rst_n,
  prd_in_if.sink    in_bus,
  prd_out_if.source out_bus,
  prd_cfg_if.sink   cfg_bus
);

  prd_pkg::prd_cfg_t                cfg_r;
  prd_pkg::prd_cmd_t                cmd;

  logic                             in_xfer;
  logic                             s1_move;
  logic                             s1_valid_r;
  logic                             s1_marker_r;
  logic [prd_pkg::ADDR_W-1:0]       s1_addr_r;
  logic [prd_pkg::COUNT_W-1:0]      s1_count_r;
  logic                             s1_done_r;
  logic [prd_pkg::COLOR_W-1:0]      rd_color;

  logic                             out_valid_r;
  logic [prd_pkg::ADDR_W-1:0]       out_addr_r;
  logic [prd_pkg::COLOR_W-1:0]      out_color_r;
  logic [prd_pkg::COUNT_W-1:0]      out_count_r;
  logic                             out_done_r;

  // Configuration registers
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red_rs   <= prd_pkg::RED_RS_RST;
      cfg_r.red_ls   <= prd_pkg::RED_LS_RST;
      cfg_r.green_rs <= prd_pkg::GREEN_RS_RST;
      cfg_r.green_ls <= prd_pkg::GREEN_LS_RST;
      cfg_r.blue_rs  <= prd_pkg::BLUE_RS_RST;
      cfg_r.blue_ls  <= prd_pkg::BLUE_LS_RST;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        prd_pkg::REG_RED_RS:   cfg_r.red_rs   <= cfg_bus.data;
        prd_pkg::REG_RED_LS:   cfg_r.red_ls   <= cfg_bus.data;
        prd_pkg::REG_GREEN_RS: cfg_r.green_rs <= cfg_bus.data;
        prd_pkg::REG_GREEN_LS: cfg_r.green_ls <= cfg_bus.data;
        prd_pkg::REG_BLUE_RS:  cfg_r.blue_rs  <= cfg_bus.data;
        prd_pkg::REG_BLUE_LS:  cfg_r.blue_ls  <= cfg_bus.data;
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // Advance the read stage when the output register is free or draining
  assign s1_move      = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || s1_move;
  assign in_xfer      = in_bus.valid && in_bus.ready;

  prd_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_xfer),
    .stream_byte   (in_bus.stream_byte),
    .frame_restart (in_bus.frame_restart),
    .cfg           (cfg_r),
    .cmd           (cmd)
  );

  // Palette writes land at the transfer edge; reads of the same byte's
  // index come back aligned with the read stage.
  prd_palette u_palette (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_xfer && cmd.wr_en),
    .wr_idx  (cmd.wr_idx),
    .wr_data (cmd.wr_color),
    .rd_en   (in_xfer && cmd.emit && !cmd.marker),
    .rd_idx  (cmd.rd_idx),
    .rd_data (rd_color)
  );

  // Read stage: hold run fields while the palette read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= cmd.emit;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_marker_r <= cmd.marker;
      s1_addr_r   <= cmd.addr;
      s1_count_r  <= cmd.count;
      s1_done_r   <= cmd.done;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_addr_r  <= s1_addr_r;
      out_color_r <= s1_marker_r ? '0 : rd_color;
      out_count_r <= s1_count_r;
      out_done_r  <= s1_done_r;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.pixel_address = out_addr_r;
  assign out_bus.pixel_color   = out_color_r;
  assign out_bus.run_count     = out_count_r;
  assign out_bus.frame_done    = out_done_r;

endmodule

>>> bench/palette_rle_frame_decoder_test.sv
`timescale 1ns / 1ps

module palette_rle_frame_decoder_test;
  import prd_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000; // quiet cycles before the run is declared hung
  localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off in the pressure test
  localparam int unsigned DRAIN_CYCLES = 4;    // read stage + output register, with margin
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned MAX_GAP      = 16;

  // One run as it leaves the block
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] count;
    logic               done;
  } run_t;

  logic clk = 1'b0;
  logic rst_n;

  prd_in_if  in_bus ();
  prd_out_if out_bus ();
  prd_cfg_if cfg_bus ();

  palette_rle_frame_decoder DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder shadow state. It advances once per accepted input transfer and
  // queues the run that the byte produces, if any.
  // ---------------------------------------------------------------------------
  prd_cfg_t      shifts = '{RED_RS_RST, RED_LS_RST, GREEN_RS_RST,
                            GREEN_LS_RST, BLUE_RS_RST, BLUE_LS_RST};
  phase_t        parse_ph = PH_COUNT_LO;
  logic [15:0]   palette [PALETTE_DEPTH] = '{default: '0};
  logic [15:0]   entries_left = '0;
  logic [15:0]   entry_index = '0;
  logic [15:0]   color_bytes = '0;   // red in the low byte, green in the high byte
  int unsigned   wr_off = 0;         // kept wide: a skip may overshoot 17 bits
  logic [7:0]    lit_left = '0;      // also the byte position inside a triplet
  logic [7:0]    skip_lo = '0;

  run_t          pending_runs [$];
  int unsigned   mismatches = 0;
  int unsigned   bytes_sent = 0;

  bit            in_gaps_on = 1'b1;
  bit            out_gaps_on = 1'b1;
  int unsigned   hold_request = 0;   // picked up by the result sink before its next transfer

  function automatic logic [15:0] shift_term(input logic [7:0] b, input logic [4:0] rs,
                                             input logic [4:0] ls);
    logic [31:0] t;
    t = ({24'h0, b} >> rs) << ls;
    return t[15:0];  // drop what lands above bit 15
  endfunction

  function automatic void expect_run(input int unsigned addr, input logic [15:0] color,
                                     input int unsigned count, input logic done);
    run_t r;
    r.addr  = ADDR_W'(addr);
    r.color = color;
    r.count = COUNT_W'(count);
    r.done  = done;
    pending_runs.push_back(r);
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic restart);
    logic [15:0] pal_color;
    int unsigned n;
    int unsigned rest;
    int unsigned addr;
    logic        last;
    if (restart) parse_ph = PH_COUNT_LO;
    case (parse_ph)
      PH_COUNT_LO: begin
        entries_left = {8'h00, b};
        parse_ph = PH_COUNT_HI;
      end
      PH_COUNT_HI: begin
        entries_left[15:8] = b;
        entry_index = '0;
        lit_left = '0;
        wr_off = 0;
        // an empty palette goes straight to the body
        parse_ph = (entries_left != 0) ? PH_PALETTE : PH_OPCODE;
      end
      PH_PALETTE: begin
        if (lit_left == 0) begin
          color_bytes = {8'h00, b};
          lit_left = 8'd1;
        end else if (lit_left == 1) begin
          color_bytes[15:8] = b;
          lit_left = 8'd2;
        end else begin
          pal_color = shift_term(color_bytes[7:0], shifts.red_rs, shifts.red_ls)
                    + shift_term(color_bytes[15:8], shifts.green_rs, shifts.green_ls)
                    + shift_term(b, shifts.blue_rs, shifts.blue_ls);
          // entries past the end of the palette are read and thrown away
          if (entry_index < PALETTE_DEPTH) palette[entry_index[7:0]] = pal_color;
          entry_index = entry_index + 16'd1;
          entries_left = entries_left - 16'd1;
          lit_left = '0;
          if (entries_left == 0) parse_ph = PH_OPCODE;
        end
      end
      PH_OPCODE: begin
        if (b == OP_SKIP) begin
          parse_ph = PH_SKIP_LO;
        end else if (b < OP_REPEAT_MIN) begin
          lit_left = b;
          parse_ph = PH_LITERAL;
        end else begin
          lit_left = b - OP_REPEAT_BASE;
          parse_ph = PH_REPEAT;
        end
      end
      PH_SKIP_LO: begin
        skip_lo = b;
        parse_ph = PH_SKIP_HI;
      end
      PH_SKIP_HI: begin
        wr_off = wr_off + {b, skip_lo};
        if (wr_off >= FRAME_PIXELS) begin
          // saturate and close the frame with an end marker
          wr_off = FRAME_PIXELS;
          parse_ph = PH_COUNT_LO;
          expect_run(FRAME_PIXELS, '0, 0, 1'b1);
        end else begin
          parse_ph = PH_OPCODE;
        end
      end
      PH_LITERAL: begin
        lit_left = lit_left - 8'd1;
        if (wr_off < FRAME_PIXELS) begin
          addr = wr_off;
          wr_off = wr_off + 1;
          last = (lit_left == 0) && (wr_off >= FRAME_PIXELS);
          if (lit_left == 0) parse_ph = last ? PH_COUNT_LO : PH_OPCODE;
          expect_run(addr, palette[b], 1, last);
        end else if (lit_left == 0) begin
          // literal bytes past the frame end are swallowed; the last one marks the end
          parse_ph = PH_COUNT_LO;
          expect_run(FRAME_PIXELS, '0, 0, 1'b1);
        end
      end
      PH_REPEAT: begin
        n = lit_left;
        rest = FRAME_PIXELS - wr_off;
        if (n > rest) n = rest;  // clip at the frame end
        addr = wr_off;
        wr_off = wr_off + n;
        last = (wr_off >= FRAME_PIXELS);
        parse_ph = last ? PH_COUNT_LO : PH_OPCODE;
        lit_left = '0;
        expect_run(addr, palette[b], n, last);
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stream side. valid stays high across back-to-back transfers; it is only
  // lowered at the step where a gap starts or the stream pauses.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic restart);
    int unsigned gap;
    gap = in_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.stream_byte   <= b;
    in_bus.frame_restart <= restart;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    decode_byte(b, restart);
    bytes_sent++;
  endtask

  // Force a restart whenever the decoder is not already waiting for a header; otherwise restart on request or at random
  task automatic send_header(input logic [15:0] count, input logic force_restart);
    logic restart;
    restart = force_restart || (parse_ph != PH_COUNT_LO) || ($urandom_range(0, 1) == 1);
    send_byte(count[7:0], restart);
    send_byte(count[15:8], 1'b0);
  endtask

  task automatic send_skip(input logic [15:0] skip);
    send_byte(OP_SKIP, 1'b0);
    send_byte(skip[7:0], 1'b0);
    send_byte(skip[15:8], 1'b0);
  endtask

  task automatic send_repeat(input int unsigned n, input logic [7:0] idx);
    send_byte(OP_REPEAT_BASE + 8'(n), 1'b0);
    send_byte(idx, 1'b0);
  endtask

  task automatic send_literal(input int unsigned n);
    send_byte(8'(n), 1'b0);
    repeat (n) send_byte(8'($urandom), 1'b0);
  endtask

  // Skip forward in the body until the write offset reaches target
  task automatic advance_to(input int unsigned target);
    while (parse_ph == PH_OPCODE && wr_off < target)
      send_skip((target - wr_off > 65535) ? 16'hFFFF : 16'(target - wr_off));
  endtask

  // Stop the stream and wait for every queued run, then for the pipeline to settle
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg valid high; the caller drops it after the last transfer
  task automatic write_shift(input logic [CFG_IDX_W-1:0] idx, input logic [SHIFT_W-1:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= v;
    @(posedge clk);
    while (cfg_bus.ready !== 1'b1) @(posedge clk);
    case (idx)
      REG_RED_RS:   shifts.red_rs   = v;
      REG_RED_LS:   shifts.red_ls   = v;
      REG_GREEN_RS: shifts.green_rs = v;
      REG_GREEN_LS: shifts.green_ls = v;
      REG_BLUE_RS:  shifts.blue_rs  = v;
      REG_BLUE_LS:  shifts.blue_ls  = v;
      default: begin
      end
    endcase
  endtask

  task automatic apply_shifts(input prd_cfg_t s);
    drain();
    write_shift(REG_RED_RS,   s.red_rs);
    write_shift(REG_RED_LS,   s.red_ls);
    write_shift(REG_GREEN_RS, s.green_rs);
    write_shift(REG_GREEN_LS, s.green_ls);
    write_shift(REG_BLUE_RS,  s.blue_rs);
    write_shift(REG_BLUE_LS,  s.blue_ls);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic prd_cfg_t random_shifts();
    logic [31:0] r;
    r = $urandom;
    return r[$bits(prd_cfg_t)-1:0];
  endfunction

  // One well-formed frame with random content and a random way of ending
  task automatic run_random_frame();
    int unsigned n_pal;
    int unsigned rem;
    n_pal = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
    send_header(16'(n_pal), 1'b0);
    repeat (3 * n_pal) send_byte(8'($urandom), 1'b0);
    for (int i = 0; i < int'($urandom_range(1, 8)); i++) begin
      if (parse_ph != PH_OPCODE) break;
      case ($urandom_range(0, 3))
        0: send_skip(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300)));
        1: send_literal(($urandom_range(0, 15) == 0) ? $urandom_range(1, 128)
                                                     : $urandom_range(1, 6));
        default: send_repeat($urandom_range(1, 127), 8'($urandom));
      endcase
    end
    if (parse_ph == PH_OPCODE) begin
      case ($urandom_range(0, 4))
        0: begin
          // repeat that reaches or runs over the frame end and gets clipped there
          advance_to(FRAME_PIXELS - $urandom_range(1, 126));
          rem = FRAME_PIXELS - wr_off;
          send_repeat($urandom_range(rem, 127), 8'($urandom));
        end
        1: begin
          // literal that ends exactly at, or runs past, the frame end
          advance_to(FRAME_PIXELS - $urandom_range(1, 4));
          rem = FRAME_PIXELS - wr_off;
          send_literal(rem + $urandom_range(0, 4));
        end
        2: begin
          while (parse_ph == PH_OPCODE) send_skip(16'($urandom_range(30000, 65535)));
        end
        default: begin
          // leave the frame open; the next header restarts
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every opcode kind, byte extremes, an unwritten palette index, a zero skip
  // and a skip that saturates at the frame end
  task automatic test_opcodes();
    send_header(16'd2, 1'b1);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h01, 1'b0);
    send_repeat(127, 8'd0);
    send_byte(8'd1, 1'b0);  // literal of one
    send_byte(8'd1, 1'b0);
    send_repeat(1, 8'hFF);
    send_skip(16'h0000);
    send_skip(16'hFFFF);
    send_skip(16'hFFFF);
  endtask

  // Empty palette, clipped repeat, literal past the end, literal ending exactly
  task automatic test_frame_end();
    send_header(16'd0, 1'b0);
    advance_to(FRAME_PIXELS - 2);
    send_repeat(127, 8'd0);
    send_header(16'd0, 1'b0);
    advance_to(FRAME_PIXELS - 1);
    send_literal(3);
    send_header(16'd0, 1'b0);
    advance_to(FRAME_PIXELS - 2);
    send_literal(2);
  endtask

  // Abandon a frame inside a literal and inside a triplet; the palette survives
  task automatic test_restart();
    send_header(16'd1, 1'b0);
    send_byte(8'h10, 1'b0); send_byte(8'h20, 1'b0); send_byte(8'h30, 1'b0);
    send_byte(8'd5, 1'b0);  // literal of five, cut short
    send_byte(8'd0, 1'b0);
    send_byte(8'd1, 1'b0);
    send_header(16'd3, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_header(16'd0, 1'b1);
    send_repeat(3, 8'd0);
    send_repeat(2, 8'd1);
  endtask

  // More triplets than palette entries; the extra ones must not wrap around
  task automatic test_palette_overflow();
    in_gaps_on = 1'b0;
    send_header(16'd258, 1'b0);
    repeat (258 * 3) send_byte(8'($urandom), 1'b0);
    send_repeat(5, 8'd0);
    send_repeat(5, 8'd1);
    send_repeat(5, 8'hFF);
    in_gaps_on = 1'b1;
  endtask

  // Hold the result side off long enough to fill the pipe and stall the stream,
  // then pause the stream until every run is out
  task automatic test_backpressure();
    hold_request = HOLD_CYCLES;
    in_gaps_on = 1'b0;
    send_header(16'd2, 1'b1);
    repeat (6) send_byte(8'($urandom), 1'b0);
    send_literal(48);
    send_repeat(100, 8'd1);
    drain();
    in_gaps_on = 1'b1;
    send_literal(6);
    send_repeat(20, 8'd0);
  endtask

  // Several shift settings, extremes included, each loaded into a fresh palette
  task automatic test_shift_settings();
    prd_cfg_t s;
    for (int k = 0; k < 7; k++) begin
      case (k)
        0: s = '0;
        1: s = '1;
        2: s = '{5'd0, 5'd15, 5'd31, 5'd0, 5'd0, 5'd31};
        3: s = '{5'd7, 5'd16, 5'd0, 5'd8, 5'd8, 5'd0};
        6: s = '{RED_RS_RST, RED_LS_RST, GREEN_RS_RST, GREEN_LS_RST, BLUE_RS_RST, BLUE_LS_RST};
        default: s = random_shifts();
      endcase
      apply_shifts(s);
      in_gaps_on = (k % 2 == 1);
      send_header(16'd4, 1'b0);
      send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
      repeat (6) send_byte(8'($urandom), 1'b0);
      for (int i = 0; i < 4; i++) send_repeat($urandom_range(1, 127), 8'(i));
    end
    in_gaps_on = 1'b1;
  endtask

  // Mostly well-formed frames, some noise and some shift changes in between
  task automatic test_random_frames();
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      in_gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 11))
        0: apply_shifts(random_shifts());
        1: repeat ($urandom_range(1, 12)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        default: run_random_frame();
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: draw a stall per run, honor a requested hold-off, and check
  // every transfer against the oldest queued run
  // ---------------------------------------------------------------------------
  task automatic check_run();
    run_t want;
    if (pending_runs.size() == 0) begin
      $error("unexpected run: address %0d count %0d", out_bus.pixel_address, out_bus.run_count);
      mismatches++;
      return;
    end
    want = pending_runs.pop_front();
    if (out_bus.pixel_address !== want.addr) begin
      $error("pixel_address: expected %0d, got %0d", want.addr, out_bus.pixel_address);
      mismatches++;
    end
    if (out_bus.pixel_color !== want.color) begin
      $error("pixel_color: expected 0x%04h, got 0x%04h", want.color, out_bus.pixel_color);
      mismatches++;
    end
    if (out_bus.run_count !== want.count) begin
      $error("run_count: expected %0d, got %0d", want.count, out_bus.run_count);
      mismatches++;
    end
    if (out_bus.frame_done !== want.done) begin
      $error("frame_done: expected %0b, got %0b", want.done, out_bus.frame_done);
      mismatches++;
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      // flip now and then so long runs without stalls show up as well
      if ($urandom_range(0, 23) == 0) out_gaps_on = !out_gaps_on;
      stall = out_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (out_bus.valid !== 1'b1) @(posedge clk);
      check_run();
    end
  end

  // Watchdog: any transfer on any channel counts as progress
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) === 1'b1 ||
          (out_bus.valid && out_bus.ready) === 1'b1 ||
          (cfg_bus.valid && cfg_bus.ready) === 1'b1)
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n                <= 1'b0;
    in_bus.valid         <= 1'b0;
    in_bus.stream_byte   <= '0;
    in_bus.frame_restart <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= '0;
    cfg_bus.data         <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_opcodes();
    test_frame_end();
    test_restart();
    test_palette_overflow();
    test_backpressure();
    test_shift_settings();
    test_random_frames();

    drain();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
